// ----- rtl/core/srk_pkg.sv -----
`default_nettype none

package srk_pkg;

  typedef logic signed [31:0] key_t;

  localparam key_t KEY_RESET = 32'sd1000000;
  localparam key_t KEY_MAX   = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN   = 32'sh8000_0000;

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  // Signed add clamped to the 32-bit range.
  function automatic key_t sat_add(key_t a, key_t b);
    logic [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
        return s[32] ? KEY_MIN : KEY_MAX;
      end
      return key_t'(s[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/srk_req_if.sv -----
`default_nettype none

interface srk_req_if import srk_pkg::*;;
  logic valid;
  logic ready;
  logic action;
  logic [2:0] entry_index;
  key_t amount;

  modport source (output valid, output action, output entry_index, output amount,
                  input ready);
  modport sink (input valid, input action, input entry_index, input amount,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srk_rsp_if.sv -----
`default_nettype none

interface srk_rsp_if import srk_pkg::*;;
  logic valid;
  logic ready;
  key_t new_key;
  logic [2:0] entry_rank;
  logic [2:0] lowest_entry;

  modport source (output valid, output new_key, output entry_rank, output lowest_entry,
                  input ready);
  modport sink (input valid, input new_key, input entry_rank, input lowest_entry,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srk_cell.sv -----
`default_nettype none

module srk_cell import srk_pkg::*; #(
  parameter int EW = 3,
  parameter int RESET_ENTRY = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic [EW-1:0] in_entry,
  input  key_t          in_key,
  output logic [EW-1:0] entry,
  output key_t          key
);

  // One slot of the rank-ordered ring: which entry sits here and its key.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= EW'(RESET_ENTRY);
      key   <= KEY_RESET;
    end else if (shift) begin
      entry <= in_entry;
      key   <= in_key;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srk_ctrl.sv -----
`default_nettype none

module srk_ctrl import srk_pkg::*; #(
  parameter int ENTRIES = 8,
  localparam int EW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst,
  srk_req_if.sink       req,
  srk_rsp_if.source     rsp,
  input  logic [EW-1:0] head_entry,
  input  key_t          head_key,
  input  logic [EW-1:0] next_entry,
  input  key_t          next_key,
  output logic          shift,
  output logic [EW-1:0] tail_entry,
  output key_t          tail_key
);

  localparam logic [EW-1:0] LAST = EW'(ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_MERGE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [EW-1:0] cnt;
  logic [EW-1:0] pos;
  logic [EW-1:0] rank;
  logic          op_action;
  logic [2:0]    op_idx;
  key_t          op_amount;
  key_t          okey;
  key_t          nkey;
  logic          bad;
  logic          ins;
  logic [EW-1:0] prev_entry;
  key_t          prev_key;

  logic accept;
  logic in_range;
  logic hit;
  logic last;
  logic ahead;
  logic take;
  logic rsp_free;
  logic rsp_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = 32'(req.entry_index) < ENTRIES;
  assign hit       = (8'(head_entry) == 8'(op_idx));
  assign last      = (cnt == LAST);
  assign ahead     = (cnt < pos);
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = (state == S_FINISH) && rsp_free;

  // During the merge pass the ring streams out in rank order and is rebuilt with the
  // updated entry taken out of its old slot and dropped into its new one. Each output
  // slot is the previous, current or next old element, or the updated entry itself.
  always_comb begin
    shift      = 1'b0;
    tail_entry = head_entry;
    tail_key   = head_key;
    take       = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = in_range ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        shift = 1'b1;
        if (last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        shift = 1'b1;
        if (ahead) begin
          if (ins) begin
            tail_entry = prev_entry;
            tail_key   = prev_key;
          end else if (nkey < head_key) begin
            take = 1'b1;
          end
        end else if (ins) begin
          if (cnt == pos) begin
            tail_entry = prev_entry;
            tail_key   = prev_key;
          end
        end else if (last || nkey <= next_key) begin
          take = 1'b1;
        end else begin
          tail_entry = next_entry;
          tail_key   = next_key;
        end
        if (take) begin
          tail_entry = EW'(op_idx);
          tail_key   = nkey;
        end
        if (last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ins       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_action <= req.action;
            op_idx    <= req.entry_index;
            op_amount <= req.amount;
            bad       <= !in_range;
            cnt       <= '0;
          end
        end
        S_SCAN: begin
          if (hit) begin
            pos  <= cnt;
            okey <= head_key;
          end
          cnt <= last ? '0 : cnt + 1'b1;
        end
        S_UPDATE: begin
          nkey <= (op_action == ACT_SET) ? op_amount : sat_add(okey, op_amount);
          ins  <= 1'b0;
        end
        S_MERGE: begin
          prev_entry <= head_entry;
          prev_key   <= head_key;
          if (take) begin
            ins  <= 1'b1;
            rank <= cnt;
          end
          cnt <= last ? '0 : cnt + 1'b1;
        end
        S_FINISH: begin
          if (rsp_load) begin
            rsp.new_key      <= bad ? '0 : nkey;
            rsp.entry_rank   <= bad ? 3'd0 : 3'(rank);
            rsp.lowest_entry <= 3'(head_entry);
          end
        end
        default: ;
      endcase
    end
  end

  // The updated entry must have been placed by the end of the merge pass.
  a_placed: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE && last |=> ins)
    else $error("updated entry not placed during merge");

  // The ring is back in rank alignment whenever the block waits for work.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cnt == '0)
    else $error("ring position counter not at zero while idle");

  // A found slot always lies inside the ring.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE && !bad |-> pos <= LAST)
    else $error("entry slot outside the ring");

  // A result beat only appears on the way out of the finish state.
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_FINISH))
    else $error("result beat raised outside finish");

endmodule

`default_nettype wire

// ----- rtl/core/stable_rank_by_key_table_core.sv -----
`default_nettype none

// Stable rank-by-key table. The entries live in a ring of ENTRIES cells kept in
// ascending key order; every update sets or saturating-adds one entry's key and
// then re-ranks stably, so equal keys keep their previous order. An in-range
// request runs through the scan, update and merge states before the next one
// is accepted: the ring rotates once past the single compare point at its head
// to find the entry, the update state forms the new key, and a second full
// rotation rebuilds the order with the entry in its new slot. A request whose
// index is not below ENTRIES leaves the table alone and goes straight to the
// finish state, which raises its result.
// The result sits in an output register, so a result not yet taken only holds
// the block when the following request is ready to report.

module stable_rank_by_key_table_core import srk_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst,
  srk_req_if.sink   req,
  srk_rsp_if.source rsp
);

  localparam int EW = $clog2(ENTRIES);

  logic [EW-1:0] cell_entry [ENTRIES];
  key_t          cell_key   [ENTRIES];
  logic          shift;
  logic [EW-1:0] tail_entry;
  key_t          tail_key;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      srk_cell #(.EW(EW), .RESET_ENTRY(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .in_entry (tail_entry),
        .in_key   (tail_key),
        .entry    (cell_entry[i]),
        .key      (cell_key[i])
      );
    end else begin : g_body
      srk_cell #(.EW(EW), .RESET_ENTRY(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .in_entry (cell_entry[i+1]),
        .in_key   (cell_key[i+1]),
        .entry    (cell_entry[i]),
        .key      (cell_key[i])
      );
    end
  end

  srk_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .head_entry (cell_entry[0]),
    .head_key   (cell_key[0]),
    .next_entry (cell_entry[1]),
    .next_key   (cell_key[1]),
    .shift      (shift),
    .tail_entry (tail_entry),
    .tail_key   (tail_key)
  );

endmodule

`default_nettype wire

// ----- verif/stable_rank_by_key_table_core_test.sv -----
module stable_rank_by_key_table_core_test;
  import srk_pkg::*;

  localparam int NUM_ENTRIES = 8;
  localparam int RANK_LATENCY = 2 * NUM_ENTRIES + 3;
  localparam int RANDOM_UPDATES = 2000;

  typedef struct {
    key_t       new_key;
    logic [2:0] entry_rank;
    logic [2:0] lowest_entry;
  } rank_result_t;

  logic clk;
  logic rst;

  srk_req_if req_ch ();
  srk_rsp_if rsp_ch ();

  stable_rank_by_key_table_core #(.ENTRIES(NUM_ENTRIES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Shadow copy of the table.
  key_t       key_tbl [NUM_ENTRIES];
  logic [2:0] rank_tbl[NUM_ENTRIES];

  rank_result_t pending_results[$];
  rank_result_t got_expected;

  int errors;
  int updates_sent;
  int results_checked;
  int burst_left;
  int ready_hold;
  bit free_flow;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void reset_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      key_tbl[i] = KEY_RESET;
      rank_tbl[i] = 3'(i);
    end
  endfunction

  // Applies one update to the shadow table, re-ranks it stably and returns
  // the result the block must report.
  function automatic rank_result_t apply_update(logic act, logic [2:0] idx, key_t amt);
    int order[NUM_ENTRIES];
    int tmp;
    longint sum;
    rank_result_t res;
    for (int i = 0; i < NUM_ENTRIES; i++) order[i] = i;
    for (int i = 0; i < NUM_ENTRIES; i++) order[rank_tbl[i]] = i;
    if (int'(idx) >= NUM_ENTRIES) begin
      res.new_key = '0;
      res.entry_rank = '0;
      res.lowest_entry = 3'(order[0]);
      return res;
    end
    if (act == ACT_SET) begin
      key_tbl[idx] = amt;
    end else begin
      sum = longint'(key_tbl[idx]) + longint'(amt);
      if (sum > longint'(KEY_MAX)) sum = longint'(KEY_MAX);
      if (sum < longint'(KEY_MIN)) sum = longint'(KEY_MIN);
      key_tbl[idx] = key_t'(sum);
    end
    // Swapping only on a strict greater-than keeps equal keys in their old order.
    for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
      for (int j = 0; j < NUM_ENTRIES - 1 - i; j++) begin
        if (key_tbl[order[j]] > key_tbl[order[j + 1]]) begin
          tmp = order[j];
          order[j] = order[j + 1];
          order[j + 1] = tmp;
        end
      end
    end
    for (int p = 0; p < NUM_ENTRIES; p++) rank_tbl[order[p]] = 3'(p);
    res.new_key = key_tbl[idx];
    res.entry_rank = rank_tbl[idx];
    res.lowest_entry = 3'(order[0]);
    return res;
  endfunction

  // Sends one update beat; the sender idles between bursts, of random length unless in free-flow mode.
  task automatic send_update(input logic act, input logic [2:0] idx, input key_t amt);
    int gap;
    if (burst_left == 0) begin
      if (req_ch.valid) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
      burst_left = free_flow ? 1000 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.entry_index <= idx;
    req_ch.amount <= amt;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_update(act, idx, amt));
    updates_sent++;
  endtask

  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    if (req_ch.valid) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    burst_left = 0;
    while (pending_results.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("results still outstanding after %0d cycles: %0d", limit,
             pending_results.size());
      errors++;
    end
  endtask

  task automatic test_reset_state();
    // An add of zero is a read; after reset every entry ranks by its index.
    for (int i = 0; i < NUM_ENTRIES; i++) send_update(ACT_ADD, 3'(i), 32'sd0);
  endtask

  task automatic test_extremes();
    send_update(ACT_SET, 3'd3, KEY_MAX);
    send_update(ACT_SET, 3'd5, KEY_MIN);
    send_update(ACT_ADD, 3'd3, KEY_MAX);
    send_update(ACT_ADD, 3'd5, KEY_MIN);
    send_update(ACT_ADD, 3'd3, 32'sd1);
    send_update(ACT_ADD, 3'd5, -32'sd1);
    send_update(ACT_ADD, 3'd5, KEY_MAX);
    send_update(ACT_ADD, 3'd3, KEY_MIN);
    send_update(ACT_SET, 3'd2, KEY_MAX);
    send_update(ACT_SET, 3'd6, KEY_MAX);
    send_update(ACT_SET, 3'd0, 32'sd0);
    send_update(ACT_ADD, 3'd0, -32'sd1);
    send_update(ACT_SET, 3'd7, 32'sh0000_0000);
    send_update(ACT_SET, 3'd1, -32'sd1);
    // Ties: entries that become equal must keep their previous relative order.
    send_update(ACT_SET, 3'd4, -32'sd1);
    send_update(ACT_SET, 3'd1, -32'sd1);
    send_update(ACT_ADD, 3'd7, -32'sd1);
    send_update(ACT_ADD, 3'd4, 32'sd0);
  endtask

  task automatic test_pause_for_drain();
    for (int i = 0; i < 6; i++) send_update(1'($urandom), 3'($urandom), key_t'($urandom));
    drain_results(10000);
    repeat ($urandom_range(1, 30)) @(negedge clk);
    for (int i = 0; i < 6; i++) send_update(ACT_SET, 3'(i), KEY_RESET);
  endtask

  task automatic test_random_updates();
    key_t pool[8];
    key_t amt;
    logic act;
    int pick;
    pool = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2, KEY_MAX, KEY_MIN, KEY_RESET};
    for (int n = 0; n < RANDOM_UPDATES; n++) begin
      if (n % 250 == 0) free_flow = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        act = ACT_SET;
        amt = pool[$urandom_range(0, 7)];
      end else if (pick < 65) begin
        act = ACT_ADD;
        amt = key_t'($signed($urandom_range(0, 6)) - 3);
      end else if (pick < 75) begin
        // Large steps toward either bound drive the clamp.
        act = ACT_ADD;
        amt = $urandom_range(0, 1) ? (KEY_MAX - key_t'($urandom_range(0, 3)))
                                   : (KEY_MIN + key_t'($urandom_range(0, 3)));
      end else if (pick < 88) begin
        act = ACT_ADD;
        amt = key_t'($urandom);
      end else begin
        act = ACT_SET;
        amt = key_t'($urandom);
      end
      send_update(act, 3'($urandom_range(0, NUM_ENTRIES - 1)), amt);
      if (n == RANDOM_UPDATES / 2) begin
        drain_results(10000);
        repeat ($urandom_range(1, 25)) @(negedge clk);
      end
    end
  endtask

  // Receiver: alternating ready and stall stretches of random length; in free-flow mode it stays ready.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      if (free_flow || !rsp_ch.ready) begin
        rsp_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(1, 40);
      end else begin
        rsp_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(1, 30);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no update outstanding: new_key %0d", rsp_ch.new_key);
        errors++;
      end else begin
        got_expected = pending_results.pop_front();
        results_checked++;
        if (rsp_ch.new_key !== got_expected.new_key) begin
          $error("new_key: expected %0d, got %0d", got_expected.new_key, rsp_ch.new_key);
          errors++;
        end
        if (rsp_ch.entry_rank !== got_expected.entry_rank) begin
          $error("entry_rank: expected %0d, got %0d", got_expected.entry_rank,
                 rsp_ch.entry_rank);
          errors++;
        end
        if (rsp_ch.lowest_entry !== got_expected.lowest_entry) begin
          $error("lowest_entry: expected %0d, got %0d", got_expected.lowest_entry,
                 rsp_ch.lowest_entry);
          errors++;
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    errors = 0;
    updates_sent = 0;
    results_checked = 0;
    burst_left = 0;
    ready_hold = 0;
    free_flow = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_SET;
    req_ch.entry_index = '0;
    req_ch.amount = '0;
    rsp_ch.ready = 1'b0;
    reset_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_extremes();
    test_pause_for_drain();
    test_random_updates();

    drain_results(200000);
    repeat (RANK_LATENCY + 20) @(posedge clk);

    $display("tb: %0d updates sent, %0d results checked", updates_sent, results_checked);
    $display("tb: covered reads, sets, clamped adds at both bounds and ties across all entries");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/srk_pkg.sv
rtl/core/srk_req_if.sv
rtl/core/srk_rsp_if.sv
rtl/core/srk_cell.sv
rtl/core/srk_ctrl.sv
rtl/core/stable_rank_by_key_table_core.sv
verif/stable_rank_by_key_table_core_test.sv
